[rtl/block_dialect_weight_decoder_defines.svh]
// Assertion helpers shared by the decoder RTL.
// Both expect clk and rst_n in scope.
`ifndef BLOCK_DIALECT_WEIGHT_DECODER_DEFINES_SVH
`define BLOCK_DIALECT_WEIGHT_DECODER_DEFINES_SVH

// Same-cycle implication.
`define BDWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdwd assertion failed");

// Next-cycle implication.
`define BDWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdwd assertion failed");

`endif

[rtl/bdwd_pkg.sv]
package bdwd_pkg;

    localparam int PAIRS_PER_BLOCK = 16;

    // byte positions inside a block
    localparam logic [4:0] POS_HDR0  = 5'd0;
    localparam logic [4:0] POS_HDR1  = 5'd1;
    localparam logic [4:0] POS_FIRST = 5'd2;
    localparam logic [4:0] POS_LAST  = 5'(PAIRS_PER_BLOCK + 1);

    localparam logic [6:0] MAG_MAX = 7'd127;

    localparam logic [3:0] DIALECT_TABLE [16][8] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4,  4'd4,  4'd4},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd3,  4'd4,  4'd4},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,  4'd5,  4'd5},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4,  4'd5,  4'd5},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,  4'd6,  4'd6},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4,  4'd6,  4'd6},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,  4'd6,  4'd7},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,  4'd7,  4'd7},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd7,  4'd8},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd8,  4'd8},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd8,  4'd10},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd10, 4'd10},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd10, 4'd12},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd12, 4'd12},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd12, 4'd15},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6,  4'd13, 4'd15}
    };

    // one packed byte plus the block context it decodes under
    typedef struct packed {
        logic [7:0] codes;
        logic [3:0] table_sel;
        logic [4:0] exponent;
        logic       last;
    } pair_t;

endpackage

[rtl/block_dialect_weight_decoder.sv]
// out_valid rises once a packed byte has passed the input register and then the result register.
// Throughput: one byte per cycle while in_stall is low; header bytes yield no result.
// Two register stages (input, result); both move unless the result is stalled.
// Reset (async, active low) clears block position, table, exponent and valids;
// the first byte after reset is taken as a block header.
`include "block_dialect_weight_decoder_defines.svh"

module block_dialect_weight_decoder
    import bdwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic        [7:0] block_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] weight_first,
    output logic signed [7:0] weight_second,
    output logic              block_last
);

    logic              advance;
    logic              pair_valid;
    pair_t             pair;
    logic signed [7:0] dec_first, dec_second;

    logic              out_valid_reg, out_valid_next;
    logic signed [7:0] first_reg, second_reg;
    logic              last_reg;

    assign advance = !out_valid_reg || !out_stall;

    bdwd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .block_byte (block_byte),
        .advance    (advance),
        .pair_valid (pair_valid),
        .pair       (pair)
    );

    bdwd_decode u_dec_hi (
        .code      (pair.codes[7:4]),
        .table_sel (pair.table_sel),
        .exponent  (pair.exponent),
        .weight    (dec_first)
    );

    bdwd_decode u_dec_lo (
        .code      (pair.codes[3:0]),
        .table_sel (pair.table_sel),
        .exponent  (pair.exponent),
        .weight    (dec_second)
    );

    assign out_valid_next = advance ? pair_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pair_valid)
        begin
            first_reg  <= dec_first;
            second_reg <= dec_second;
            last_reg   <= pair.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign weight_first  = first_reg;
    assign weight_second = second_reg;
    assign block_last    = last_reg;

    // saturation keeps weights symmetric: -128 never appears
    `BDWD_ASSERT_NOW(a_no_min_weight, out_valid_reg,
        first_reg != 8'sh80 && second_reg != 8'sh80)
    `BDWD_ASSERT_NOW(a_stall_cause, in_stall, out_stall && out_valid_reg)

endmodule

[rtl/bdwd_decode.sv]
module bdwd_decode
    import bdwd_pkg::*;
(
    input  logic              [3:0] code,
    input  logic              [3:0] table_sel,
    input  logic              [4:0] exponent,
    output logic signed       [7:0] weight
);

    logic [3:0]  mag_tab;
    logic [4:0]  shift;
    logic [4:0]  rounded;
    logic [10:0] shifted;
    logic [6:0]  mag;
    logic [7:0]  mag8;

    always_comb
    begin
        mag_tab = DIALECT_TABLE[table_sel][code[2:0]];
        shift   = exponent - 5'd1;
        rounded = {1'b0, mag_tab} + 5'd1;
        shifted = {7'd0, mag_tab} << shift[2:0];

        if (exponent == 5'd0)
        begin
            mag = {3'd0, rounded[4:1]};
        end
        else if (mag_tab == 4'd0)
        begin
            mag = 7'd0;
        end
        else if (shift >= 5'd7)
        begin
            mag = MAG_MAX;
        end
        else if (shifted > {4'd0, MAG_MAX})
        begin
            mag = MAG_MAX;
        end
        else
        begin
            mag = shifted[6:0];
        end

        mag8   = {1'b0, mag};
        // negative zero folds to zero naturally
        weight = code[3] ? $signed(8'(-mag8)) : $signed(mag8);
    end

endmodule

[rtl/bdwd_front.sv]
`include "block_dialect_weight_decoder_defines.svh"

module bdwd_front
    import bdwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] block_byte,
    input  logic       advance,
    output logic       pair_valid,
    output pair_t      pair
);

    logic [4:0] pos_reg, pos_next;
    logic [3:0] table_reg, table_next;
    logic [4:0] exp_reg, exp_next;
    logic       pair_valid_reg, pair_valid_next;
    pair_t      pair_reg, pair_next;
    logic       accept;

    assign in_stall   = pair_valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        table_next      = table_reg;
        exp_next        = exp_reg;
        pair_valid_next = advance ? 1'b0 : pair_valid_reg;
        pair_next       = pair_reg;

        if (accept)
        begin
            case (pos_reg)
                POS_HDR0:
                begin
                    table_next = block_byte[7:4];
                    exp_next   = {block_byte[3:0], 1'b0};
                    pos_next   = POS_HDR1;
                end
                POS_HDR1:
                begin
                    exp_next = {exp_reg[4:1], block_byte[7]};
                    pos_next = POS_FIRST;
                end
                default:
                begin
                    pair_valid_next     = 1'b1;
                    pair_next.codes     = block_byte;
                    pair_next.table_sel = table_reg;
                    pair_next.exponent  = exp_reg;
                    pair_next.last      = (pos_reg >= POS_LAST);
                    pos_next            = (pos_reg >= POS_LAST) ? POS_HDR0
                                                                : pos_reg + 5'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HDR0;
            table_reg      <= 4'd0;
            exp_reg        <= 5'd0;
            pair_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            table_reg      <= table_next;
            exp_reg        <= exp_next;
            pair_valid_reg <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    `BDWD_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= POS_LAST)
    `BDWD_ASSERT_NEXT(a_block_wrap, accept && pos_reg == POS_LAST,
        pos_reg == POS_HDR0 && pair_valid_reg && pair_reg.last)
    `BDWD_ASSERT_NOW(a_last_at_hdr, pair_valid_reg && pair_reg.last, pos_reg == POS_HDR0)

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

typedef struct {
    logic signed [7:0] w_hi;
    logic signed [7:0] w_lo;
    logic              last;
} weight_pair_t;

class weight_pair_scoreboard;
    logic [4:0] byte_pos;
    logic [3:0] table_sel;
    logic [4:0] exponent;
    weight_pair_t pending_pairs[$];
    int mismatches;

    function new();
        byte_pos   = '0;
        table_sel  = '0;
        exponent   = '0;
        mismatches = 0;
    endfunction

    // sign bit plus 3-bit index into the block's dialect table
    function logic signed [7:0] decode_nibble(logic [3:0] code);
        logic [31:0] row;
        int m;
        int mag;
        case (table_sel)
            4'h0: row = 32'h4444_3210;
            4'h1: row = 32'h4433_3210;
            4'h2: row = 32'h5554_3210;
            4'h3: row = 32'h5543_3210;
            4'h4: row = 32'h6654_3210;
            4'h5: row = 32'h6644_3210;
            4'h6: row = 32'h7654_3210;
            4'h7: row = 32'h7754_3210;
            4'h8: row = 32'h8764_3210;
            4'h9: row = 32'h8864_3210;
            4'hA: row = 32'hA864_3210;
            4'hB: row = 32'hAA64_3210;
            4'hC: row = 32'hCA64_3210;
            4'hD: row = 32'hCC64_3210;
            4'hE: row = 32'hFC64_3210;
            default: row = 32'hFD64_3210;
        endcase
        m = row[code[2:0] * 4 +: 4];
        if (exponent == 0)
            mag = (m + 1) >> 1;
        else if (m == 0)
            mag = 0;
        else if (exponent >= 8)
            mag = 127;
        else
        begin
            mag = m << (exponent - 1);
            if (mag > 127)
                mag = 127;
        end
        if (code[3])
            mag = -mag;
        return mag[7:0];
    endfunction

    function void note_byte(logic [7:0] b);
        weight_pair_t p;
        if (byte_pos == 0)
        begin
            table_sel = b[7:4];
            exponent  = {b[3:0], 1'b0};
            byte_pos  = 5'd1;
        end
        else if (byte_pos == 1)
        begin
            exponent[0] = b[7];
            byte_pos    = 5'd2;
        end
        else
        begin
            p.w_hi = decode_nibble(b[7:4]);
            p.w_lo = decode_nibble(b[3:0]);
            if (byte_pos >= bdwd_pkg::PAIRS_PER_BLOCK + 1)
            begin
                p.last   = 1'b1;
                byte_pos = 5'd0;
            end
            else
            begin
                p.last   = 1'b0;
                byte_pos = byte_pos + 5'd1;
            end
            pending_pairs.push_back(p);
        end
    endfunction

    function void check_pair(logic signed [7:0] wf, logic signed [7:0] ws, logic lst);
        weight_pair_t p;
        if (pending_pairs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pair: %0d %0d last=%0b", wf, ws, lst);
            return;
        end
        p = pending_pairs.pop_front();
        if (wf !== p.w_hi || ws !== p.w_lo || lst !== p.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pair mismatch: expected %0d %0d last=%0b, got %0d %0d last=%0b",
                         p.w_hi, p.w_lo, p.last, wf, ws, lst);
        end
    endfunction

    function int pending();
        return pending_pairs.size();
    endfunction
endclass

module tb;
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic        [7:0] block_byte;
    logic              out_valid;
    logic              out_stall;
    logic signed [7:0] weight_first;
    logic signed [7:0] weight_second;
    logic              block_last;

    weight_pair_scoreboard sb = new();

    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int rx_hold_len = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;

    wire byte_xfer = in_valid && !in_stall;
    wire pair_xfer = out_valid && !out_stall;

    block_dialect_weight_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .block_byte    (block_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .weight_first  (weight_first),
        .weight_second (weight_second),
        .block_last    (block_last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_xfer)
                sb.note_byte(block_byte);
            if (pair_xfer)
                sb.check_pair(weight_first, weight_second, block_last);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && (byte_xfer || pair_xfer))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        block_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic pick_idle_modes();
        case ($urandom_range(0, 3))
            0: tx_gap_max = 0;
            1: tx_gap_max = 2;
            default: tx_gap_max = 8;
        endcase
        case ($urandom_range(0, 3))
            0: rx_gap_max = 0;
            1: rx_gap_max = 2;
            default: rx_gap_max = 8;
        endcase
    endtask

    // receiver: per result a random hold-off, or one long hold when requested
    initial
    begin : rx_side
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                n = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                n = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [7:0] directed_codes[$];
        logic [3:0] tsel;
        logic [4:0] ex;
        int blk;
        directed_codes = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF,
                           8'h80, 8'h08, 8'hFF, 8'h00, 8'h77, 8'hF0, 8'h3C, 8'h5A};
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        block_byte <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // exponent 0 (rounding), widest table, every code, negative zero
        pick_idle_modes();
        send_byte(8'hF0);
        send_byte(8'h00);
        foreach (directed_codes[i])
            send_byte(directed_codes[i]);
        // exponent 15: every nonzero magnitude saturates
        send_byte(8'hF7);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hF7);
        send_byte(8'h12);
        send_byte(8'h9A);
        send_byte(8'h08);
        repeat (bdwd_pkg::PAIRS_PER_BLOCK - 5)
            send_byte(8'($urandom));

        blk = 0;
        while (bytes_sent < 500)
        begin
            pick_idle_modes();
            if (blk == 3)
            begin
                // receiver holds off long enough that the pipeline backs up
                tx_gap_max  = 0;
                rx_hold_len = 80;
            end
            tsel = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 4))
                0: ex = 5'd0;
                1: ex = 5'd1;
                2: ex = 5'($urandom_range(2, 8));
                3: ex = 5'($urandom_range(9, 31));
                default: ex = 5'($urandom_range(0, 31));
            endcase
            send_byte({tsel, ex[4:1]});
            send_byte({ex[0], 7'($urandom)});
            repeat (bdwd_pkg::PAIRS_PER_BLOCK)
                send_byte(8'($urandom));
            blk++;
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
